// ===== rtl/pixel_blend_modes_macros.svh =====
// ----------------------------------------------------------------------------
// Pixel blend modes assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_BLEND_MODES_MACROS_SVH
`define PIXEL_BLEND_MODES_MACROS_SVH

// same-cycle implication
`define PBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel blend modes package
// Types, constants and arithmetic helpers shared by the blend datapath.
// ----------------------------------------------------------------------------
package pbm_pkg;

    localparam int NUM_CH        = 4;
    localparam int CH_W          = 8;
    localparam int LANES_DEFAULT = 4;
    localparam int STAGES        = 5;
    localparam int LANE_STAGES   = 4;
    localparam int MODE_W        = 4;
    localparam int CHAN_W        = 3;
    localparam int SQ_W          = 2 * CH_W;

    localparam logic [MODE_W-1:0] MODE_RESET = 4'd3;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 3'd4;

    typedef enum logic [MODE_W-1:0] {
        MODE_SAT_ADD  = 4'd0,
        MODE_AMPL     = 4'd1,
        MODE_AND      = 4'd2,
        MODE_AVG      = 4'd3,
        MODE_XFADE    = 4'd4,
        MODE_ABS_DIFF = 4'd5,
        MODE_MAX      = 4'd6,
        MODE_MIN      = 4'd7,
        MODE_MUL      = 4'd8,
        MODE_OR       = 4'd9,
        MODE_SUB      = 4'd10,
        MODE_XOR      = 4'd11
    } blend_mode_t;

    typedef enum logic {
        CFG_BLEND_MODE    = 1'b0,
        CFG_CHANNELS_USED = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [CH_W-1:0] a_ch0;
        logic [CH_W-1:0] a_ch1;
        logic [CH_W-1:0] a_ch2;
        logic [CH_W-1:0] a_ch3;
        logic [CH_W-1:0] b_ch0;
        logic [CH_W-1:0] b_ch1;
        logic [CH_W-1:0] b_ch2;
        logic [CH_W-1:0] b_ch3;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] out_ch0;
        logic [CH_W-1:0] out_ch1;
        logic [CH_W-1:0] out_ch2;
        logic [CH_W-1:0] out_ch3;
    } pix_out_t;

    typedef logic [NUM_CH-1:0][CH_W-1:0] lane_vec_t;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] root;
    } sqrt_state_t;

    // one digit of the bitwise integer square root
    function automatic sqrt_state_t sqrt_step(sqrt_state_t s, logic [SQ_W-1:0] b);
        sqrt_state_t   n;
        logic [SQ_W:0] sum;
        sum = {1'b0, s.root} + {1'b0, b};
        if ({1'b0, s.v} >= sum) begin
            n.v    = s.v - sum[SQ_W-1:0];
            n.root = (s.root >> 1) + b;
        end
        else begin
            n.v    = s.v;
            n.root = s.root >> 1;
        end
        return n;
    endfunction

endpackage

// ===== rtl/pbm_lane.sv =====
// ----------------------------------------------------------------------------
// Pixel blend lane
// Four-stage blend of one channel pair: products, sum and divide by 255,
// then the square root in two halves, and the final mode select.
// ----------------------------------------------------------------------------
module pbm_lane
    import pbm_pkg::*;
(
    input  logic                   clk,
    input  logic [LANE_STAGES-1:0] adv,
    input  logic [CH_W-1:0]        x,
    input  logic [CH_W-1:0]        y,
    input  logic [MODE_W-1:0]      mode,
    output logic [CH_W-1:0]        result
);

    blend_mode_t     mode_sel;
    logic [CH_W:0]   sum9;
    logic [CH_W+1:0] fade;
    logic [CH_W-1:0] simple_next;

    logic [SQ_W-1:0] xx_reg, yy_reg, xy_reg;
    logic [CH_W-1:0] simple1_reg;

    logic [SQ_W:0]   sq_sum;
    logic [SQ_W:0]   quot_sum;
    logic [SQ_W-1:0] half_reg;
    logic [CH_W-1:0] quot2_reg, simple2_reg;

    sqrt_state_t     s3_next, s4_next;
    sqrt_state_t     s3_reg;
    logic [CH_W-1:0] quot3_reg, simple3_reg;

    logic [CH_W-1:0] root4_reg, quot4_reg, simple4_reg;

    assign mode_sel = blend_mode_t'(mode);
    assign sum9     = {1'b0, x} + {1'b0, y};
    assign fade     = {2'b00, x} + {1'b0, x, 1'b0} + {2'b00, y};

    always_comb
    begin
        unique case (mode_sel)
            MODE_SAT_ADD:  simple_next = sum9[CH_W] ? {CH_W{1'b1}} : sum9[CH_W-1:0];
            MODE_AND:      simple_next = x & y;
            MODE_XFADE:    simple_next = fade[CH_W+1:2];
            MODE_ABS_DIFF: simple_next = (x >= y) ? (x - y) : (y - x);
            MODE_MAX:      simple_next = (x >= y) ? x : y;
            MODE_MIN:      simple_next = (x <= y) ? x : y;
            MODE_OR:       simple_next = x | y;
            MODE_SUB:      simple_next = (x >= y) ? (x - y) : '0;
            MODE_XOR:      simple_next = x ^ y;
            default:       simple_next = sum9[CH_W:1];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            xx_reg      <= x * x;
            yy_reg      <= y * y;
            xy_reg      <= x * y;
            simple1_reg <= simple_next;
        end
    end

    // x*y/255 exact for products below 65535
    assign sq_sum   = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign quot_sum = {1'b0, xy_reg} + {{(CH_W+1){1'b0}}, xy_reg[SQ_W-1:CH_W]}
                      + {{SQ_W{1'b0}}, 1'b1};

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            half_reg    <= sq_sum[SQ_W:1];
            quot2_reg   <= quot_sum[SQ_W-1:CH_W];
            simple2_reg <= simple1_reg;
        end
    end

    always_comb
    begin
        s3_next.v    = half_reg;
        s3_next.root = '0;
        for (int k = 0; k < 4; k++)
        begin
            s3_next = sqrt_step(s3_next, SQ_W'(1) << (14 - 2 * k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_reg      <= s3_next;
            quot3_reg   <= quot2_reg;
            simple3_reg <= simple2_reg;
        end
    end

    always_comb
    begin
        s4_next = s3_reg;
        for (int k = 0; k < 4; k++)
        begin
            s4_next = sqrt_step(s4_next, SQ_W'(1) << (6 - 2 * k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            root4_reg   <= s4_next.root[CH_W-1:0];
            quot4_reg   <= quot3_reg;
            simple4_reg <= simple3_reg;
        end
    end

    always_comb
    begin
        unique case (mode_sel)
            MODE_AMPL: result = root4_reg;
            MODE_MUL:  result = quot4_reg;
            default:   result = simple4_reg;
        endcase
    end

endmodule

// ===== rtl/pbm_merge.sv =====
// ----------------------------------------------------------------------------
// Pixel blend merge
// Masks unused lanes and packs the lane results into the output register.
// ----------------------------------------------------------------------------
module pbm_merge
    import pbm_pkg::*;
#(
    parameter int LANES = LANES_DEFAULT
)
(
    input  logic              clk,
    input  logic              adv,
    input  lane_vec_t         lane_res,
    input  logic [CHAN_W-1:0] channels_used,
    output pix_out_t          blend
);

    lane_vec_t masked;
    pix_out_t  blend_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            if ((i < LANES) && (CHAN_W'(i) < channels_used))
            begin
                masked[i] = lane_res[i];
            end
            else
            begin
                masked[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            blend_reg.out_ch0 <= masked[0];
            blend_reg.out_ch1 <= masked[1];
            blend_reg.out_ch2 <= masked[2];
            blend_reg.out_ch3 <= masked[3];
        end
    end

    assign blend = blend_reg;

endmodule

// ===== rtl/pixel_blend_modes.sv =====
// ----------------------------------------------------------------------------
// Pixel blend modes
// Per-channel blend of two 4-channel pixels under a configured mode.
// ----------------------------------------------------------------------------
// Usage:
//   pix channel (valid/ready) carries one request: a pixel pair a_ch*, b_ch*.
//   blend channel (valid/ready) returns one blended pixel per request,
//   in order. Unused channels read as 0.
//   APB port: 0x0 blend_mode, 0x4 channels_used; pready is always high.
//   Change registers only while no request is in flight.
// Pipeline: five register stages between request accept and blend valid
//   (four lane stages, the square root split over two of them, plus
//   the output register), the first one loaded at the accepting edge.
// Throughput: one request per cycle unless the output is stalled; every stage
//   holds its own valid bit, so bubbles close up while the output is stalled.
// Reset: pipeline empties, blend_mode = 3 (average), channels_used = 4.
// Stall: when blend_ready is low the output holds; pix_ready drops only
//   once all five stages are full.
// ----------------------------------------------------------------------------
`include "pixel_blend_modes_macros.svh"

module pixel_blend_modes
    import pbm_pkg::*;
#(
    parameter int LANES = LANES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        pix_valid,
    output logic        pix_ready,
    input  pix_in_t     pix,
    output logic        blend_valid,
    input  logic        blend_ready,
    output pix_out_t    blend
);

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic              cfg_wr;
    cfg_idx_t          cfg_idx;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] adv;

    lane_vec_t         a_vec, b_vec, lane_res;

    // configuration
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = cfg_idx_t'(paddr[2]);

    always_comb
    begin
        mode_next = mode_reg;
        chan_next = chan_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                CFG_BLEND_MODE:    mode_next = pwdata[MODE_W-1:0];
                CFG_CHANNELS_USED: chan_next = pwdata[CHAN_W-1:0];
                default:           mode_next = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            CFG_BLEND_MODE:    prdata = {{(32-MODE_W){1'b0}}, mode_reg};
            CFG_CHANNELS_USED: prdata = {{(32-CHAN_W){1'b0}}, chan_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            chan_reg <= CHAN_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            chan_reg <= chan_next;
        end
    end

    // pipeline flow control
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || blend_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = pix_valid;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign pix_ready   = adv[0];
    assign blend_valid = vld_reg[STAGES-1];

    // lanes
    assign a_vec = {pix.a_ch3, pix.a_ch2, pix.a_ch1, pix.a_ch0};
    assign b_vec = {pix.b_ch3, pix.b_ch2, pix.b_ch1, pix.b_ch0};

    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_lane
        if (i < LANES)
        begin : g_on
            pbm_lane u_lane (
                .clk    (clk),
                .adv    (adv[LANE_STAGES-1:0]),
                .x      (a_vec[i]),
                .y      (b_vec[i]),
                .mode   (mode_reg),
                .result (lane_res[i])
            );
        end
        else
        begin : g_off
            assign lane_res[i] = '0;
        end
    end

    pbm_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk           (clk),
        .adv           (adv[STAGES-1]),
        .lane_res      (lane_res),
        .channels_used (chan_reg),
        .blend         (blend)
    );

    `PBM_ASSERT_NOW(a_full_on_block, !pix_ready, &vld_reg,
        "request blocked with an empty stage")
    `PBM_ASSERT_NEXT(a_req_enters, pix_valid && pix_ready, vld_reg[0],
        "accepted request not captured")
    `PBM_ASSERT_NEXT(a_no_loss, vld_reg[STAGES-2] && adv[STAGES-1], vld_reg[STAGES-1],
        "request lost entering output register")

endmodule
